### rtl/dmst_pkg.sv
package dmst_pkg;

  typedef enum logic [1:0] {
    DRIVE_OFF = 2'd0,
    DRIVE_FWD = 2'd1,
    DRIVE_REV = 2'd2
  } drive_t;

  localparam logic [1:0] REG_TOGGLE_WINDOW  = 2'd0;
  localparam logic [1:0] REG_TOGGLES_NEEDED = 2'd1;
  localparam logic [1:0] REG_MOTOR_TIMEOUT  = 2'd2;

  localparam logic [7:0]  TOGGLE_WINDOW_RST  = 8'd10;
  localparam logic [3:0]  TOGGLES_NEEDED_RST = 4'd4;
  localparam logic [15:0] MOTOR_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] RUN_TIME_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  toggle_window;
    logic [3:0]  toggles_needed;
    logic [15:0] motor_timeout;
  } cfg_t;

  typedef struct packed {
    logic        lever_state;
    logic [3:0]  edge_count;
    logic [7:0]  edge_timer;
    logic        run_active;
    logic        reversing;
    logic [15:0] run_time;
    logic        error_latched;
  } seq_state_t;

  typedef struct packed {
    logic lever;
    logic lim_rev;
    logic lim_stop;
    logic alarm;
  } tick_t;

  typedef struct packed {
    drive_t motor_drive;
    logic   door_busy;
    logic   fault;
    logic   lever_on;
  } result_t;

endpackage

### rtl/dmst_step.sv
module dmst_step import dmst_pkg::*; (
  input  cfg_t       cfg,
  input  seq_state_t cur,
  input  tick_t      tick,
  output seq_state_t state_nxt,
  output result_t    res
);

  seq_state_t s;
  drive_t     drive;

  always_comb begin
    s     = cur;
    drive = DRIVE_OFF;
    if (s.error_latched) begin
      s.edge_count = '0;
      s.edge_timer = '0;
    end else begin
      if (tick.lever != s.lever_state) begin
        // a lever edge counts only inside the window since the last one
        if (s.edge_timer <= cfg.toggle_window) begin
          s.edge_count = s.edge_count + 4'd1;
          if (s.edge_count >= cfg.toggles_needed) begin
            s.edge_count = '0;
            s.run_active = 1'b1;
            s.reversing  = 1'b0;
            s.run_time   = '0;
          end
        end
        s.edge_timer = '0;
      end
      s.lever_state = tick.lever;

      if (s.edge_timer >= cfg.toggle_window) begin
        s.edge_count = '0;
      end
      if (s.edge_timer < cfg.toggle_window && s.edge_count != '0) begin
        s.edge_timer = s.edge_timer + 8'd1;
      end

      if (!s.run_active) begin
        // idle sleep: drop the edge timer
        if (!s.lever_state && s.edge_count == '0) begin
          s.edge_timer = '0;
        end
        if (tick.alarm) begin
          s.run_active = 1'b1;
          s.reversing  = 1'b0;
          s.run_time   = '0;
        end
      end else begin
        drive = s.reversing ? DRIVE_REV : DRIVE_FWD;
        if (tick.lim_rev) begin
          s.reversing = 1'b1;
        end
        if (tick.lim_stop && s.reversing) begin
          drive        = DRIVE_OFF;
          s.run_active = 1'b0;
          s.edge_count = '0;
          s.edge_timer = '0;
        end
        if (s.run_time != RUN_TIME_MAX) begin
          s.run_time = s.run_time + 16'd1;
        end
        if (s.run_active && s.run_time >= cfg.motor_timeout) begin
          s.error_latched = 1'b1;
          drive           = DRIVE_OFF;
          s.edge_count    = '0;
          s.edge_timer    = '0;
        end
      end
    end
  end

  assign state_nxt       = s;
  assign res.motor_drive = drive;
  assign res.door_busy   = s.run_active;
  assign res.fault       = s.error_latched;
  assign res.lever_on    = s.lever_state;

endmodule

### rtl/door_motor_sequencer_with_toggle_trigger.sv
// Door motor sequencer, one item per 1 ms tick. An item is taken every clock
// cycle while in_stall is low; its result goes through the input register and
// then the result register, and a combinational state update between them
// keeps one item per cycle flowing when out_stall is low. Lever edges that
// come within toggle_window ticks of each other are counted; toggles_needed of
// them, or a due alarm while idle, start a run: forward until limit_reverse,
// then reverse until limit_stop. A run reaching motor_timeout ticks latches a
// fault that holds the motor off until reset. Write configuration only while
// no item is in flight; cfg_ready is always high and index 3 is ignored.
module door_motor_sequencer_with_toggle_trigger import dmst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_lever_level,
  input  logic        in_limit_reverse,
  input  logic        in_limit_stop,
  input  logic        in_alarm_due,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_motor_drive,
  output logic        out_door_busy,
  output logic        out_fault,
  output logic        out_lever_on,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic       in_v_r;
  tick_t      tick_r;
  logic       out_v_r;
  result_t    res_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  result_t    res_nxt;
  cfg_t       cfg_r;
  logic       adv;
  logic       in_take;

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  dmst_step u_step (
    .cfg       (cfg_r),
    .cur       (state_r),
    .tick      (tick_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r                <= 1'b0;
      out_v_r               <= 1'b0;
      state_r.lever_state   <= 1'b0;
      state_r.edge_count    <= '0;
      state_r.edge_timer    <= TOGGLE_WINDOW_RST;
      state_r.run_active    <= 1'b0;
      state_r.reversing     <= 1'b0;
      state_r.run_time      <= '0;
      state_r.error_latched <= 1'b0;
      cfg_r.toggle_window   <= TOGGLE_WINDOW_RST;
      cfg_r.toggles_needed  <= TOGGLES_NEEDED_RST;
      cfg_r.motor_timeout   <= MOTOR_TIMEOUT_RST;
    end else begin
      in_v_r <= in_take || (in_v_r && !adv);
      if (adv) begin
        state_r <= state_nxt;
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          REG_TOGGLE_WINDOW:  cfg_r.toggle_window  <= cfg_data[7:0];
          REG_TOGGLES_NEEDED: cfg_r.toggles_needed <= cfg_data[3:0];
          REG_MOTOR_TIMEOUT:  cfg_r.motor_timeout  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      tick_r.lever    <= in_lever_level;
      tick_r.lim_rev  <= in_limit_reverse;
      tick_r.lim_stop <= in_limit_stop;
      tick_r.alarm    <= in_alarm_due;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_v_r;
  assign out_motor_drive = res_r.motor_drive;
  assign out_door_busy   = res_r.door_busy;
  assign out_fault       = res_r.fault;
  assign out_lever_on    = res_r.lever_on;

endmodule

### rtl/dmst_checker.sv
module dmst_checker import dmst_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_motor_drive,
  input logic        out_door_busy,
  input logic        out_fault,
  input logic        out_lever_on
);

  // a latched fault never clears on later items
  a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |=> !out_valid || out_fault)
    else $error("fault cleared after latching");

  // motor runs only inside a run and without a fault
  a_drive_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_motor_drive != DRIVE_OFF |-> out_door_busy && !out_fault)
    else $error("motor driven outside a healthy run");

  a_drive_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_drive == DRIVE_OFF || out_motor_drive == DRIVE_FWD
      || out_motor_drive == DRIVE_REV)
    else $error("unused motor drive code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_motor_drive)
      && $stable(out_door_busy) && $stable(out_fault) && $stable(out_lever_on))
    else $error("stalled result changed");

endmodule

bind door_motor_sequencer_with_toggle_trigger dmst_checker u_dmst_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_motor_drive (out_motor_drive),
  .out_door_busy   (out_door_busy),
  .out_fault       (out_fault),
  .out_lever_on    (out_lever_on)
);
